/* hw/rtl/fdem_pkg.sv */
// ----------------------------------------------------------------------------
// fdem_pkg
// Shared types and field widths for the forward-difference edge map core.
// ----------------------------------------------------------------------------
package fdem_pkg;

  // Result field widths as seen on the output stream
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;
  localparam int GRAD_W = 9;

  // Input and output stream data widths (whole bytes)
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int MAX_HEIGHT   = 4096;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } fdem_reg_t;

  // One result item without its end-of-run flag
  typedef struct packed {
    logic [GRAD_W-1:0] grad;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } fdem_res_t;

  // Number of results held for one pixel (0 to 3)
  typedef logic [1:0] fdem_cnt_t;

endpackage

/* hw/rtl/forward_difference_edge_map_core.sv */
// ----------------------------------------------------------------------------
// forward_difference_edge_map_core
// L1 forward-difference gradient over a raster pixel stream with a line store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one grey pixel per transfer, raster order, frame after frame.
//   out_* : one result per transfer: the pixel's row and column and the sum of
//           absolute differences to its right and lower neighbors. tlast marks
//           the final result released by one input pixel.
//   cfg_* : image width and height; a write restarts the frame at row 0.
//           Write only while the core is idle.
// Release: a result leaves through the pixel stage and result buffer
//   registers once a pixel releases it. The result for row r appears when
//   the pixel below arrives; on the last row, when its right neighbor arrives.
// Throughput: one pixel per cycle on all rows but the last while out_tready is
//   high; a last-row pixel releases up to three results, handed out one per
//   transfer, and the pixel stage holds until the result buffer takes them.
// Reset: counters at frame start, height 1024, width 1024 or MAX_WIDTH if less;
//   the line store is not cleared, as only rows of the current frame are read.
// Stall: when out_tready is low the result buffer holds and in_tready drops
//   once the pixel stage behind it holds a pixel with results.
// ----------------------------------------------------------------------------
module forward_difference_edge_map_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg write port
  input  logic                            cfg_we,
  input  logic [fdem_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fdem_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fdem_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] pixel
  // output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fdem_pkg::OUT_DATA_W-1:0] out_tdata,  // [11:0] out_row,
                                                      // [21:12] out_col,
                                                      // [30:22] gradient, [31] zero
  output logic                            out_tlast   // last_in_run
);

  import fdem_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PB_IN = (PIXEL_BITS < IN_DATA_W) ? PIXEL_BITS : IN_DATA_W;
  localparam int SUM_W = PIXEL_BITS + 1;
  localparam logic [CW-1:0] WLAST_RST = (1024 > MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : CW'(1023);

  // Frame geometry, held as last column and last row
  logic [CW-1:0]    wlast_r;
  logic [ROW_W-1:0] hlast_r;
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;
  logic [CW-1:0]    wlast_cfg;
  logic [ROW_W-1:0] hlast_cfg;
  logic             cfg_hit;

  // Raster position and previous pixel
  logic [CW-1:0]         col_r;
  logic [ROW_W-1:0]      row_r;
  logic [PIXEL_BITS-1:0] prev_r;
  logic [PIXEL_BITS-1:0] pix;
  logic                  accept;
  logic                  col_end;
  logic [CW-1:0]         rd_b_addr;

  // Pixel stage
  logic                  s1_valid_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [PIXEL_BITS-1:0] s1_prev_r;
  logic [CW-1:0]         s1_col_r;
  logic [ROW_W-1:0]      s1_row_r;
  logic                  s1_up_r;
  logic                  s1_left_r;
  logic                  s1_corner_r;
  logic                  s1_right_r;
  logic                  s1_go;

  // Line store read data
  logic [PIXEL_BITS-1:0] above;
  logic [PIXEL_BITS-1:0] above_right;

  // Result assembly
  logic [PIXEL_BITS-1:0] d_down, d_right, d_left;
  logic [SUM_W-1:0]      g_up;
  fdem_res_t             res_up, res_left, res_corner;
  fdem_res_t [2:0]       res_set;
  fdem_cnt_t             res_cnt;
  logic                  buf_free;
  logic                  buf_load;
  fdem_res_t             out_res;

  // Saturate configured geometry
  assign cfg_w = cfg_wdata[WIDTH_REG_W-1:0];
  assign cfg_h = cfg_wdata[HEIGHT_REG_W-1:0];

  always_comb begin
    if (cfg_w == '0) begin
      wlast_cfg = '0;
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      wlast_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      wlast_cfg = CW'(cfg_w - 11'd1);
    end
    if (cfg_h == '0) begin
      hlast_cfg = '0;
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      hlast_cfg = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hlast_cfg = ROW_W'(cfg_h - 13'd1);
    end
  end

  assign cfg_hit = cfg_we && (cfg_addr == REG_IMAGE_WIDTH || cfg_addr == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= WLAST_RST;
      hlast_r <= ROW_W'(1023);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  wlast_r <= wlast_cfg;
        REG_IMAGE_HEIGHT: hlast_r <= hlast_cfg;
        default: ;
      endcase
    end
  end

  // Raster counters
  assign pix       = PIXEL_BITS'(in_tdata[PB_IN-1:0]);
  assign accept    = in_tvalid && in_tready;
  assign col_end   = (col_r == wlast_r);
  assign rd_b_addr = col_end ? col_r : col_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      prev_r <= pix;
      if (col_end) begin
        col_r <= '0;
        row_r <= (row_r == hlast_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Line store: read the row above at this column and the next one
  fdem_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_line_mem (
    .clk       (clk),
    .en        (accept),
    .rd_addr_a (col_r),
    .rd_addr_b (rd_b_addr),
    .wr_addr   (col_r),
    .wr_data   (pix),
    .rd_data_a (above),
    .rd_data_b (above_right)
  );

  // Pixel stage: advance when empty, when it releases nothing, or when the
  // result buffer takes its set
  assign s1_go     = !s1_valid_r || (res_cnt == 2'd0) || buf_free;
  assign in_tready = s1_go;
  assign buf_load  = s1_valid_r && (res_cnt != 2'd0) && buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_go) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r    <= pix;
      s1_prev_r   <= prev_r;
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_up_r     <= (row_r != '0);
      s1_left_r   <= (row_r == hlast_r) && (col_r != '0);
      s1_corner_r <= (row_r == hlast_r) && col_end;
      s1_right_r  <= !col_end;
    end
  end

  // Differences and the result set of one pixel
  always_comb begin
    d_down  = (s1_pix_r > above) ? s1_pix_r - above : above - s1_pix_r;
    d_right = (above_right > above) ? above_right - above : above - above_right;
    d_left  = (s1_pix_r > s1_prev_r) ? s1_pix_r - s1_prev_r : s1_prev_r - s1_pix_r;
    g_up    = SUM_W'(d_down) + (s1_right_r ? SUM_W'(d_right) : '0);

    res_up.row     = s1_row_r - ROW_W'(1);
    res_up.col     = COL_W'(s1_col_r);
    res_up.grad    = GRAD_W'(g_up);
    res_left.row   = s1_row_r;
    res_left.col   = COL_W'(s1_col_r - CW'(1));
    res_left.grad  = GRAD_W'(d_left);
    res_corner.row = s1_row_r;
    res_corner.col = COL_W'(s1_col_r);
    res_corner.grad = '0;

    res_cnt = fdem_cnt_t'(s1_up_r) + fdem_cnt_t'(s1_left_r) + fdem_cnt_t'(s1_corner_r);

    // Pack present results from slot 0 in order: up, left, corner
    if (s1_up_r) begin
      res_set[0] = res_up;
      res_set[1] = s1_left_r ? res_left : res_corner;
    end else begin
      res_set[0] = s1_left_r ? res_left : res_corner;
      res_set[1] = res_corner;
    end
    res_set[2] = res_corner;
  end

  fdem_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (buf_load),
    .load_cnt   (res_cnt),
    .load_res   (res_set),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {1'b0, out_res.grad, out_res.col, out_res.row};

endmodule

/* hw/rtl/fdem_line_mem.sv */
// ----------------------------------------------------------------------------
// fdem_line_mem
// Line store: one row of pixels, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module fdem_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  output logic [DATA_W-1:0]        rd_data_a,
  output logic [DATA_W-1:0]        rd_data_b
);

  logic [DATA_W-1:0] store_r [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  // Read old contents and write the new pixel in the same transfer cycle
  always_ff @(posedge clk) begin
    if (en) begin
      rd_a_r           <= store_r[rd_addr_a];
      rd_b_r           <= store_r[rd_addr_b];
      store_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

/* hw/rtl/fdem_out_buf.sv */
// ----------------------------------------------------------------------------
// fdem_out_buf
// Result buffer: holds the up to three results of one pixel and hands them
// out one transfer at a time, marking the final one.
// ----------------------------------------------------------------------------
module fdem_out_buf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  fdem_pkg::fdem_cnt_t      load_cnt,
  input  fdem_pkg::fdem_res_t [2:0] load_res,
  output logic                     free,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output fdem_pkg::fdem_res_t      out_res,
  output logic                     out_tlast
);

  import fdem_pkg::*;

  fdem_res_t [2:0] slot_r;
  fdem_cnt_t       cnt_r, cnt_nxt;
  fdem_cnt_t       idx_r, idx_nxt;
  logic            take;
  logic            at_last;

  assign at_last    = (idx_r == cnt_r - 2'd1);
  assign out_tvalid = (cnt_r != 2'd0);
  assign take       = out_tvalid && out_tready;
  assign free       = !out_tvalid || (take && at_last);
  assign out_res    = slot_r[idx_r];
  assign out_tlast  = at_last;

  // Load a set, advance the read index, drop the set after its final transfer
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (take) begin
      if (at_last) begin
        cnt_nxt = 2'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (load) begin
      cnt_nxt = load_cnt;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Capture the result set
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= load_res;
    end
  end

endmodule
